// ===== design/stc_pkg.sv =====
`default_nettype none
package stc_pkg;

    localparam int COLUMNS = 16;
    localparam int ROWS    = 8;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int CROW_W  = $clog2(ROWS + 1);
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int IDX_W   = 8;
    localparam int PC_W    = 4;

    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic [3:0] C_NEXT     = 4'd0;
    localparam logic [3:0] C_ALWAYS   = 4'd1;
    localparam logic [3:0] C_NO_ITEM  = 4'd2;
    localparam logic [3:0] C_CLEAR    = 4'd3;
    localparam logic [3:0] C_READ     = 4'd4;
    localparam logic [3:0] C_OTHER    = 4'd5;
    localparam logic [3:0] C_IGNORED  = 4'd6;
    localparam logic [3:0] C_NEWLINE  = 4'd7;
    localparam logic [3:0] C_NOT_PEND = 4'd8;
    localparam logic [3:0] C_OUT_FREE = 4'd9;

    localparam logic [PC_W-1:0] S_FETCH = PC_W'(0);
    localparam logic [PC_W-1:0] S_SCRL  = PC_W'(7);
    localparam logic [PC_W-1:0] S_WRITE = PC_W'(8);
    localparam logic [PC_W-1:0] S_NL    = PC_W'(9);
    localparam logic [PC_W-1:0] S_CLR   = PC_W'(10);
    localparam logic [PC_W-1:0] S_RD    = PC_W'(11);
    localparam logic [PC_W-1:0] S_EMIT  = PC_W'(13);

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic [2:0] row;
        logic [3:0] column;
    } stc_in_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic       read_valid;
    } stc_out_t;

    typedef struct packed {
        logic [3:0]      cond;
        logic [PC_W-1:0] target;
        logic            take;
        logic            scroll;
        logic            write;
        logic            newline;
        logic            clear;
        logic            rd_issue;
        logic            rd_capture;
        logic            emit;
    } stc_ctrl_t;

    typedef struct packed {
        logic is_clear;
        logic is_read;
        logic is_other;
        logic ignored;
        logic newline;
        logic pending;
    } stc_flags_t;

    function automatic stc_ctrl_t ucode(input logic [PC_W-1:0] pc);
        stc_ctrl_t w;
        w = '0;
        case (pc)
            PC_W'(0):  begin w.take = 1'b1; w.cond = C_NO_ITEM; w.target = S_FETCH; end
            PC_W'(1):  begin w.cond = C_CLEAR;    w.target = S_CLR;   end
            PC_W'(2):  begin w.cond = C_READ;     w.target = S_RD;    end
            PC_W'(3):  begin w.cond = C_OTHER;    w.target = S_EMIT;  end
            PC_W'(4):  begin w.cond = C_IGNORED;  w.target = S_EMIT;  end
            PC_W'(5):  begin w.cond = C_NEWLINE;  w.target = S_NL;    end
            PC_W'(6):  begin w.cond = C_NOT_PEND; w.target = S_WRITE; end
            PC_W'(7):  begin w.scroll = 1'b1; w.cond = C_NEXT; end
            PC_W'(8):  begin w.write = 1'b1; w.cond = C_ALWAYS; w.target = S_EMIT; end
            PC_W'(9):  begin w.newline = 1'b1; w.cond = C_ALWAYS; w.target = S_EMIT; end
            PC_W'(10): begin w.clear = 1'b1; w.cond = C_ALWAYS; w.target = S_EMIT; end
            PC_W'(11): begin w.rd_issue = 1'b1; w.cond = C_NEXT; end
            PC_W'(12): begin w.rd_capture = 1'b1; w.cond = C_NEXT; end
            PC_W'(13): begin w.emit = 1'b1; w.cond = C_OUT_FREE; w.target = S_FETCH; end
            PC_W'(14): begin w.cond = C_ALWAYS; w.target = S_EMIT; end
            default:   begin w.cond = C_ALWAYS; w.target = S_FETCH; end
        endcase
        return w;
    endfunction

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] disp);
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, disp};
        if (sum >= (ROW_W+1)'(ROWS))
            sum = sum - (ROW_W+1)'(ROWS);
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(prow) * ADDR_W'(COLUMNS);
        return base + ADDR_W'(col);
    endfunction

endpackage
`default_nettype wire

// ===== design/stc_sequencer.sv =====
`default_nettype none
module stc_sequencer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               out_busy,
    input  wire stc_pkg::stc_flags_t flags,
    output stc_pkg::stc_ctrl_t      ctrl
);

    logic [stc_pkg::PC_W-1:0] pc_reg;
    logic [stc_pkg::PC_W-1:0] pc_next;
    logic                     jump;

    assign ctrl = stc_pkg::ucode(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            stc_pkg::C_NEXT:     jump = 1'b0;
            stc_pkg::C_ALWAYS:   jump = 1'b1;
            stc_pkg::C_NO_ITEM:  jump = !in_valid;
            stc_pkg::C_CLEAR:    jump = flags.is_clear;
            stc_pkg::C_READ:     jump = flags.is_read;
            stc_pkg::C_OTHER:    jump = flags.is_other;
            stc_pkg::C_IGNORED:  jump = flags.ignored;
            stc_pkg::C_NEWLINE:  jump = flags.newline;
            stc_pkg::C_NOT_PEND: jump = !flags.pending;
            stc_pkg::C_OUT_FREE: jump = !out_busy;
            default:             jump = 1'b1;
        endcase
        pc_next = jump ? ctrl.target : pc_reg + stc_pkg::PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= stc_pkg::S_FETCH;
        else
            pc_reg <= pc_next;
    end

endmodule
`default_nettype wire

// ===== design/stc_datapath.sv =====
`default_nettype none
module stc_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire stc_pkg::stc_in_t    in_data,
    input  wire stc_pkg::stc_ctrl_t  ctrl,
    output stc_pkg::stc_flags_t      flags,
    output stc_pkg::stc_out_t        res
);

    stc_pkg::stc_in_t                 item_reg;
    stc_pkg::stc_out_t                res_reg;
    stc_pkg::stc_out_t                res_next;
    logic [stc_pkg::ROW_W-1:0]        top_reg;
    logic [stc_pkg::ROW_W-1:0]        top_next;
    logic [stc_pkg::COL_W-1:0]        ccol_reg;
    logic [stc_pkg::COL_W-1:0]        ccol_next;
    logic [stc_pkg::CROW_W-1:0]       crow_reg;
    logic [stc_pkg::CROW_W-1:0]       crow_next;
    logic [stc_pkg::CELLS-1:0]        valid_reg;
    logic [stc_pkg::CELLS-1:0]        valid_next;
    logic [7:0]                       rd_data_reg;
    logic                             rd_hit_reg;
    logic [7:0]                       mem [stc_pkg::CELLS];

    logic [stc_pkg::ADDR_W-1:0]       wr_addr;
    logic [stc_pkg::ADDR_W-1:0]       rd_addr;
    logic [stc_pkg::ADDR_W-1:0]       scrl_base;
    logic [stc_pkg::IDX_W-1:0]        row_ext;
    logic [stc_pkg::IDX_W-1:0]        col_ext;
    logic                             in_rng;
    logic [stc_pkg::COL_W:0]          col_inc;
    logic                             take;

    assign take    = ctrl.take && in_valid;
    assign row_ext = stc_pkg::IDX_W'(item_reg.row);
    assign col_ext = stc_pkg::IDX_W'(item_reg.column);
    assign in_rng  = (row_ext < stc_pkg::IDX_W'(stc_pkg::ROWS))
                  && (col_ext < stc_pkg::IDX_W'(stc_pkg::COLUMNS));
    assign wr_addr = stc_pkg::cell_addr(
                         stc_pkg::phys_row(top_reg, crow_reg[stc_pkg::ROW_W-1:0]), ccol_reg);
    assign rd_addr = stc_pkg::cell_addr(
                         stc_pkg::phys_row(top_reg, row_ext[stc_pkg::ROW_W-1:0]),
                         col_ext[stc_pkg::COL_W-1:0]);
    assign scrl_base = stc_pkg::cell_addr(top_reg, stc_pkg::COL_W'(0));
    assign col_inc = {1'b0, ccol_reg} + (stc_pkg::COL_W+1)'(1);

    assign flags.is_clear = item_reg.action == stc_pkg::ACT_CLEAR;
    assign flags.is_read  = item_reg.action == stc_pkg::ACT_READ;
    assign flags.is_other = item_reg.action != stc_pkg::ACT_PUT;
    assign flags.ignored  = (item_reg.char_code == stc_pkg::CH_CR)
                         || (item_reg.char_code == stc_pkg::CH_NUL);
    assign flags.newline  = item_reg.char_code == stc_pkg::CH_NL;
    assign flags.pending  = crow_reg >= stc_pkg::CROW_W'(stc_pkg::ROWS);

    assign res = res_reg;

    always_comb
    begin
        top_next   = top_reg;
        ccol_next  = ccol_reg;
        crow_next  = crow_reg;
        valid_next = valid_reg;
        res_next   = res_reg;
        if (take)
            res_next = '0;
        if (ctrl.scroll)
        begin
            valid_next[scrl_base +: stc_pkg::COLUMNS] = '0;
            if (top_reg == stc_pkg::ROW_W'(stc_pkg::ROWS - 1))
                top_next = '0;
            else
                top_next = top_reg + stc_pkg::ROW_W'(1);
            crow_next = stc_pkg::CROW_W'(stc_pkg::ROWS - 1);
        end
        if (ctrl.write)
        begin
            valid_next[wr_addr] = 1'b1;
            if (col_inc >= (stc_pkg::COL_W+1)'(stc_pkg::COLUMNS))
            begin
                ccol_next = '0;
                crow_next = crow_reg + stc_pkg::CROW_W'(1);
            end
            else
                ccol_next = col_inc[stc_pkg::COL_W-1:0];
        end
        if (ctrl.newline)
        begin
            ccol_next = '0;
            if (!flags.pending)
                crow_next = crow_reg + stc_pkg::CROW_W'(1);
        end
        if (ctrl.clear)
        begin
            valid_next = '0;
            ccol_next  = '0;
            crow_next  = '0;
        end
        if (ctrl.rd_capture)
        begin
            res_next.read_valid = 1'b1;
            if (rd_hit_reg && rd_data_reg != stc_pkg::CH_NUL)
                res_next.cell_char = rd_data_reg;
            else
                res_next.cell_char = stc_pkg::CH_SPACE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= '0;
            ccol_reg  <= '0;
            crow_reg  <= '0;
            valid_reg <= '0;
        end
        else
        begin
            top_reg   <= top_next;
            ccol_reg  <= ccol_next;
            crow_reg  <= crow_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= in_data;
        res_reg <= res_next;
        if (ctrl.write)
            mem[wr_addr] <= item_reg.char_code;
        if (ctrl.rd_issue)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_hit_reg  <= in_rng && valid_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== design/scrolling_text_console_top.sv =====
`default_nettype none
// Scrolling text console: a ring of character rows with a cursor.
// Input channel in_valid/in_ready/in_data carries one item: put a character,
// clear the screen, or read one displayed cell. Output channel
// out_valid/out_ready/out_data returns exactly one result per item; only a
// read result has read_valid set, and an empty cell reads as a space.
// A microcode sequencer walks each item through a fixed program, one step
// per cycle except while the emit step waits for the output register to
// free up, and takes a new item only at its fetch step. A clear empties the
// grid, a read issues the memory read and then captures the cell, a newline
// moves the cursor, a printable character scrolls if needed and then writes
// its cell, and every item ends at the emit step. Cell reads go through
// a one-port memory with a registered read, which sets the read latency.
// Each cell has a valid bit: reset and clear empty the whole grid at once,
// and a scroll empties the freed row in the same cycle.
// Reset homes the cursor, zeroes the top-row pointer and empties all cells.
// A stalled receiver holds the result in the output register; the next
// item may be accepted meanwhile but its result waits until the register
// frees up.
module scrolling_text_console_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire stc_pkg::stc_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output stc_pkg::stc_out_t      out_data
);

    stc_pkg::stc_ctrl_t  ctrl;
    stc_pkg::stc_flags_t flags;
    stc_pkg::stc_out_t   res;
    stc_pkg::stc_out_t   out_data_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_busy;
    logic                emit_fire;

    assign out_busy  = out_valid_reg && !out_ready;
    assign emit_fire = ctrl.emit && !out_busy;
    assign in_ready  = ctrl.take;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    stc_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .flags    (flags),
        .ctrl     (ctrl)
    );

    stc_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .ctrl     (ctrl),
        .flags    (flags),
        .res      (res)
    );

    always_comb
    begin
        if (emit_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
            out_data_reg <= res;
    end

endmodule
`default_nettype wire

// ===== design/stc_checker.sv =====
`default_nettype none
module stc_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire stc_pkg::stc_out_t out_data
);

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous item in progress");

    a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after accept");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_read_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.read_valid ? out_data.cell_char != 8'd0
                                           : out_data.cell_char == 8'd0))
        else $error("result character does not match read flag");

endmodule

bind scrolling_text_console_top stc_checker u_stc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

// ===== tb/tb_scrolling_text_console_top.sv =====
`default_nettype none
module tb_scrolling_text_console_top;
    import stc_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1775;
    localparam int STALL_AT     = 1300;
    localparam int STALL_CYCLES = 400;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic [2:0] row;
        logic [3:0] column;
        logic       typed;
        logic [7:0] want_char;
        logic       want_valid;
    } plan_row_t;

    localparam int PLAN_LEN = 25;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{ACT_READ,   CH_NUL,   3'd0, 4'd0,  1'b1, CH_SPACE, 1'b1},
        '{ACT_READ,   CH_NUL,   3'd7, 4'd15, 1'b1, CH_SPACE, 1'b1},
        '{ACT_UNUSED, 8'd255,   3'd7, 4'd15, 1'b1, 8'd0,     1'b0},
        '{ACT_PUT,    8'd65,    3'd0, 4'd0,  1'b1, 8'd0,     1'b0},
        '{ACT_READ,   CH_NUL,   3'd0, 4'd0,  1'b0, 8'd0,     1'b0},
        '{ACT_PUT,    CH_CR,    3'd5, 4'd9,  1'b1, 8'd0,     1'b0},
        '{ACT_PUT,    CH_NUL,   3'd2, 4'd3,  1'b1, 8'd0,     1'b0},
        '{ACT_PUT,    8'd255,   3'd0, 4'd0,  1'b1, 8'd0,     1'b0},
        '{ACT_READ,   CH_NUL,   3'd0, 4'd1,  1'b0, 8'd0,     1'b0},
        '{ACT_PUT,    CH_NL,    3'd0, 4'd0,  1'b1, 8'd0,     1'b0},
        '{ACT_PUT,    8'd1,     3'd0, 4'd0,  1'b1, 8'd0,     1'b0},
        '{ACT_READ,   CH_NUL,   3'd1, 4'd0,  1'b0, 8'd0,     1'b0},
        '{ACT_CLEAR,  CH_NUL,   3'd7, 4'd15, 1'b1, 8'd0,     1'b0},
        '{ACT_READ,   CH_NUL,   3'd1, 4'd0,  1'b1, CH_SPACE, 1'b1},
        '{ACT_PUT,    CH_NL,    3'd0, 4'd0,  1'b1, 8'd0,     1'b0},
        '{ACT_PUT,    CH_NL,    3'd0, 4'd0,  1'b1, 8'd0,     1'b0},
        '{ACT_PUT,    CH_NL,    3'd0, 4'd0,  1'b1, 8'd0,     1'b0},
        '{ACT_PUT,    CH_NL,    3'd0, 4'd0,  1'b1, 8'd0,     1'b0},
        '{ACT_PUT,    CH_NL,    3'd0, 4'd0,  1'b1, 8'd0,     1'b0},
        '{ACT_PUT,    CH_NL,    3'd0, 4'd0,  1'b1, 8'd0,     1'b0},
        '{ACT_PUT,    CH_NL,    3'd0, 4'd0,  1'b1, 8'd0,     1'b0},
        '{ACT_PUT,    CH_NL,    3'd0, 4'd0,  1'b1, 8'd0,     1'b0},
        '{ACT_PUT,    CH_NL,    3'd0, 4'd0,  1'b1, 8'd0,     1'b0},
        '{ACT_PUT,    8'd90,    3'd0, 4'd0,  1'b1, 8'd0,     1'b0},
        '{ACT_READ,   CH_NUL,   3'd7, 4'd0,  1'b0, 8'd0,     1'b0}
    };

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    stc_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    stc_out_t out_data;

    logic steady   = 1'b0;
    logic hold_off = 1'b0;

    logic [7:0] screen_cells [CELLS];
    int top_row;
    int cur_col;
    int cur_row;

    stc_out_t awaited_replies [$];
    int accepted_items = 0;
    int mismatch_count = 0;
    int put_count      = 0;
    int read_count     = 0;
    int clear_count    = 0;
    int scroll_count   = 0;

    scrolling_text_console_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function automatic stc_out_t predict_console_reply(input stc_in_t item);
        stc_out_t reply;
        logic [7:0] ch;
        int r;
        int c;
        reply = '0;
        ch = item.char_code;
        case (item.action)
            ACT_PUT:
            begin
                put_count++;
                if (ch == CH_NL)
                begin
                    cur_col = 0;
                    if (cur_row < ROWS)
                        cur_row++;
                end
                else if (ch != CH_CR && ch != CH_NUL)
                begin
                    if (cur_row >= ROWS)
                    begin
                        for (int k = 0; k < COLUMNS; k++)
                            screen_cells[top_row * COLUMNS + k] = 8'd0;
                        top_row = (top_row + 1) % ROWS;
                        cur_row = ROWS - 1;
                        scroll_count++;
                    end
                    screen_cells[((top_row + cur_row) % ROWS) * COLUMNS + cur_col] = ch;
                    cur_col++;
                    if (cur_col >= COLUMNS)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                    if (cur_row > ROWS)
                        cur_row = ROWS;
                end
            end
            ACT_CLEAR:
            begin
                clear_count++;
                for (int k = 0; k < CELLS; k++)
                    screen_cells[k] = 8'd0;
                cur_col = 0;
                cur_row = 0;
            end
            ACT_READ:
            begin
                read_count++;
                r = int'(item.row);
                c = int'(item.column);
                reply.cell_char = CH_SPACE;
                if (r < ROWS && c < COLUMNS)
                begin
                    reply.cell_char = screen_cells[((top_row + r) % ROWS) * COLUMNS + c];
                    if (reply.cell_char == CH_NUL)
                        reply.cell_char = CH_SPACE;
                end
                reply.read_valid = 1'b1;
            end
            default: ;
        endcase
        return reply;
    endfunction

    task automatic offer(input stc_in_t item, input logic typed, input stc_out_t want);
        int gap;
        stc_out_t predicted;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 8)
            gap = $urandom_range(1, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_console_reply(item);
        awaited_replies.push_back(typed ? want : predicted);
        accepted_items++;
    endtask

    always @(posedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= steady || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge clk)
    begin
        stc_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_replies.size() == 0)
                flag_mismatch($sformatf("unexpected result char=%0d valid=%0b",
                                        out_data.cell_char, out_data.read_valid));
            else
            begin
                want = awaited_replies.pop_front();
                if (out_data.cell_char !== want.cell_char)
                    flag_mismatch($sformatf("cell_char got %0d want %0d",
                                            out_data.cell_char, want.cell_char));
                if (out_data.read_valid !== want.read_valid)
                    flag_mismatch($sformatf("read_valid got %0b want %0b",
                                            out_data.read_valid, want.read_valid));
            end
        end
    end

    initial
    begin
        wait (accepted_items >= STALL_AT);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #2000000;
        $display("scrolling_text_console_top test failed");
        $finish;
    end

    initial
    begin
        stc_in_t item;
        stc_out_t want;
        int pick;
        int nl_pct;
        int drain;
        for (int k = 0; k < CELLS; k++)
            screen_cells[k] = 8'd0;
        top_row = 0;
        cur_col = 0;
        cur_row = 0;
        nl_pct = 20;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < PLAN_LEN; n++)
        begin
            item.action    = PLAN[n].action;
            item.char_code = PLAN[n].char_code;
            item.row       = PLAN[n].row;
            item.column    = PLAN[n].column;
            want.cell_char  = PLAN[n].want_char;
            want.read_valid = PLAN[n].want_valid;
            offer(item, PLAN[n].typed, want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // every 50 items pick long lines (wrap) or short lines (scroll) at random
            if (n % 50 == 0)
                nl_pct = $urandom_range(0, 1) ? 3 : 25;
            steady <= (n >= 700 && n < 1000);
            item.char_code = 8'($urandom_range(0, 255));
            item.row       = 3'($urandom_range(0, 7));
            item.column    = 4'($urandom_range(0, 15));
            pick = $urandom_range(0, 999);
            if (pick < 570)
            begin
                item.action = ACT_PUT;
                pick = $urandom_range(0, 99);
                if (pick < nl_pct)
                    item.char_code = CH_NL;
                else if (pick < nl_pct + 3)
                    item.char_code = CH_CR;
                else if (pick < nl_pct + 5)
                    item.char_code = CH_NUL;
            end
            else if (pick < 970)
                item.action = ACT_READ;
            else if (pick < 982)
                item.action = ACT_CLEAR;
            else
                item.action = ACT_UNUSED;
            offer(item, 1'b0, '0);
        end
        in_valid <= 1'b0;
        steady <= 1'b0;

        drain = 0;
        while (awaited_replies.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (30) @(posedge clk);
        if (awaited_replies.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", awaited_replies.size()));

        $display("Covered %0d items: %0d puts, %0d reads, %0d clears, %0d scrolls,",
                 accepted_items, put_count, read_count, clear_count, scroll_count);
        $display("with random gaps on both sides and a %0d-cycle output stall.",
                 STALL_CYCLES);
        if (mismatch_count == 0)
            $display("scrolling_text_console_top test passed");
        else
            $display("scrolling_text_console_top test failed");
        $finish;
    end

endmodule
`default_nettype wire
